@@ rtl/l2p_pkg.sv @@
// Shared types, codes and widths of the logical-to-physical slot map.
package l2p_pkg;

  localparam int CW = 7;  // counts and capacity
  localparam int FW = 6;  // id and slot fields
  localparam int KW = 3;  // operation kind
  localparam int SW = 3;  // status

  localparam logic [KW-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KW-1:0] KIND_PUBLISH = 3'd1;
  localparam logic [KW-1:0] KIND_RESOLVE = 3'd2;
  localparam logic [KW-1:0] KIND_REMOVE  = 3'd3;
  localparam logic [KW-1:0] KIND_COMPACT = 3'd4;

  localparam logic [SW-1:0] ST_OK         = 3'd0;
  localparam logic [SW-1:0] ST_NO_CAP     = 3'd1;
  localparam logic [SW-1:0] ST_RANGE      = 3'd2;
  localparam logic [SW-1:0] ST_UNBOUND    = 3'd3;
  localparam logic [SW-1:0] ST_BOUND      = 3'd4;
  localparam logic [SW-1:0] ST_UNALLOC    = 3'd5;
  localparam logic [SW-1:0] ST_BAD_LAST   = 3'd6;
  localparam logic [SW-1:0] ST_CORRUPT    = 3'd7;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_NONE     = 4'd0;
  localparam cmd_t CMD_START    = 4'd1;
  localparam cmd_t CMD_RES_DONE = 4'd2;
  localparam cmd_t CMD_REM_DONE = 4'd3;
  localparam cmd_t CMD_CMP_INIT = 4'd4;
  localparam cmd_t CMD_MARK_RD  = 4'd5;
  localparam cmd_t CMD_MARK_CHK = 4'd6;
  localparam cmd_t CMD_MARK_END = 4'd7;
  localparam cmd_t CMD_SCAN     = 4'd8;
  localparam cmd_t CMD_RW_RD    = 4'd9;
  localparam cmd_t CMD_RW_SC    = 4'd10;
  localparam cmd_t CMD_RW_WR    = 4'd11;
  localparam cmd_t CMD_FINAL    = 4'd12;

  typedef struct packed {
    logic res_go;
    logic rem_go;
    logic id_done;
    logic corrupt;
    logic scan_done;
  } sts_t;

endpackage

@@ rtl/l2p_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module l2p_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/l2p_ctrl.sv @@
// Controller state machine that sequences the slot map datapath.
module l2p_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [l2p_pkg::KW-1:0] in_kind,
  input  l2p_pkg::sts_t         sts,
  output l2p_pkg::cmd_t         cmd,
  output logic                  busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RES   = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_CINIT = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MCHK  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_RWRD  = 4'd7;
  localparam logic [3:0] S_RWSC  = 4'd8;
  localparam logic [3:0] S_RWWR  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = l2p_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = l2p_pkg::CMD_START;
          if (in_kind == l2p_pkg::KIND_COMPACT) begin
            state_nxt = S_CINIT;
          end else if (sts.res_go) begin
            state_nxt = S_RES;
          end else if (sts.rem_go) begin
            state_nxt = S_REM;
          end
        end
      end
      S_RES: begin
        cmd       = l2p_pkg::CMD_RES_DONE;
        state_nxt = S_IDLE;
      end
      S_REM: begin
        cmd       = l2p_pkg::CMD_REM_DONE;
        state_nxt = S_IDLE;
      end
      S_CINIT: begin
        cmd       = l2p_pkg::CMD_CMP_INIT;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        if (sts.id_done) begin
          cmd       = l2p_pkg::CMD_MARK_END;
          state_nxt = S_SCAN;
        end else begin
          cmd       = l2p_pkg::CMD_MARK_RD;
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        cmd       = l2p_pkg::CMD_MARK_CHK;
        state_nxt = sts.corrupt ? S_IDLE : S_MRD;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_RWRD;
        end else begin
          cmd = l2p_pkg::CMD_SCAN;
        end
      end
      S_RWRD: begin
        if (sts.id_done) begin
          cmd       = l2p_pkg::CMD_FINAL;
          state_nxt = S_IDLE;
        end else begin
          cmd       = l2p_pkg::CMD_RW_RD;
          state_nxt = S_RWSC;
        end
      end
      S_RWSC: begin
        cmd       = l2p_pkg::CMD_RW_SC;
        state_nxt = S_RWWR;
      end
      S_RWWR: begin
        cmd       = l2p_pkg::CMD_RW_WR;
        state_nxt = S_RWRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/l2p_dp.sv @@
// Datapath of the slot map: table, compaction scratch, counters and result register.
module l2p_dp #(
  parameter int MAP_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  l2p_pkg::cmd_t           cmd,
  output l2p_pkg::sts_t           sts,
  input  logic [l2p_pkg::KW-1:0]  in_kind,
  input  logic [l2p_pkg::FW-1:0]  in_logical_id,
  input  logic [l2p_pkg::FW-1:0]  in_slot_in,
  input  logic [l2p_pkg::FW-1:0]  in_last_logical_id,
  input  logic                    cfg_we,
  input  logic [l2p_pkg::CW-1:0]  cfg_wdata,
  output logic                    out_strobe,
  output logic [l2p_pkg::SW-1:0]  out_status,
  output logic [l2p_pkg::FW-1:0]  out_slot_out,
  output logic                    out_is_move,
  output logic [l2p_pkg::FW-1:0]  out_move_from,
  output logic [l2p_pkg::FW-1:0]  out_move_to,
  output logic [l2p_pkg::CW-1:0]  out_slot_count,
  output logic [l2p_pkg::CW-1:0]  out_pub_total,
  output logic                    out_last
);

  localparam int AW = $clog2(MAP_DEPTH);
  localparam int CW = l2p_pkg::CW;
  localparam logic [CW-1:0] DEPTH_C = CW'(MAP_DEPTH);

  logic [CW-1:0] cap_r, cap_nxt, used_r, used_nxt, pub_r, pub_nxt;
  logic [CW-1:0] id_cnt_r, id_cnt_nxt, refd_r, refd_nxt, psnap_r, psnap_nxt;
  logic [CW-1:0] t_r, t_nxt, src_r, src_nxt, src_m1;
  logic [MAP_DEPTH-1:0] valid_r, valid_nxt, mark_r, mark_nxt;
  logic [l2p_pkg::FW-1:0] lid_r, lid_nxt, lastid_r, lastid_nxt;

  logic          tbl_we, scr_we;
  logic [AW-1:0] tbl_waddr, tbl_raddr, scr_waddr, scr_raddr;
  logic [AW-1:0] tbl_wdata, scr_wdata, tbl_rdata, scr_rdata;

  logic                   strobe_r, strobe_nxt, ismove_r, ismove_nxt;
  logic [l2p_pkg::SW-1:0] status_r, status_nxt;
  logic [l2p_pkg::FW-1:0] slot_r, slot_nxt, from_r, from_nxt, to_r, to_nxt;

  logic [CW-1:0] lid7, last7, sin7, cfg_sat;
  logic res_err_rng, rem_err_last, rem_err_rng, rem_err_unb;
  logic valid_lid, valid_last;

  l2p_ram #(.WIDTH(AW), .DEPTH(MAP_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata_r(tbl_rdata)
  );

  l2p_ram #(.WIDTH(AW), .DEPTH(MAP_DEPTH)) u_scr (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata_r(scr_rdata)
  );

  // Checks on the live input beat; ids index the valid bits before any range check.
  always_comb begin
    lid7         = {1'b0, in_logical_id};
    last7        = {1'b0, in_last_logical_id};
    sin7         = {1'b0, in_slot_in};
    valid_lid    = valid_r[in_logical_id[AW-1:0]];
    valid_last   = valid_r[in_last_logical_id[AW-1:0]];
    res_err_rng  = (lid7 >= cap_r);
    rem_err_last = (pub_r == '0) || (last7 != pub_r - 1'b1);
    rem_err_rng  = (lid7 > last7);
    rem_err_unb  = !valid_lid || !valid_last;
    cfg_sat      = (cfg_wdata > DEPTH_C) ? DEPTH_C : cfg_wdata;
    src_m1       = src_r - 1'b1;
  end

  always_comb begin
    sts.res_go    = (in_kind == l2p_pkg::KIND_RESOLVE) && !res_err_rng && valid_lid;
    sts.rem_go    = (in_kind == l2p_pkg::KIND_REMOVE) && !rem_err_last && !rem_err_rng
                    && !rem_err_unb;
    sts.id_done   = (id_cnt_r == pub_r);
    sts.corrupt   = !valid_r[id_cnt_r[AW-1:0]] || ({{(CW-AW){1'b0}}, tbl_rdata} >= psnap_r);
    sts.scan_done = (t_r >= refd_r);
  end

  always_comb begin
    cap_nxt    = cap_r;
    used_nxt   = used_r;
    pub_nxt    = pub_r;
    id_cnt_nxt = id_cnt_r;
    refd_nxt   = refd_r;
    psnap_nxt  = psnap_r;
    t_nxt      = t_r;
    src_nxt    = src_r;
    valid_nxt  = valid_r;
    mark_nxt   = mark_r;
    lid_nxt    = lid_r;
    lastid_nxt = lastid_r;
    tbl_we     = 1'b0;
    tbl_waddr  = lid_r[AW-1:0];
    tbl_wdata  = tbl_rdata;
    tbl_raddr  = id_cnt_r[AW-1:0];
    scr_we     = 1'b0;
    scr_waddr  = tbl_rdata;
    scr_wdata  = tbl_rdata;
    scr_raddr  = tbl_rdata;
    strobe_nxt = 1'b0;
    status_nxt = l2p_pkg::ST_OK;
    slot_nxt   = '0;
    ismove_nxt = 1'b0;
    from_nxt   = '0;
    to_nxt     = '0;

    if (cfg_we && (cfg_sat > cap_r)) begin
      cap_nxt = cfg_sat;
    end

    case (cmd)
      l2p_pkg::CMD_START: begin
        lid_nxt    = in_logical_id;
        lastid_nxt = in_last_logical_id;
        tbl_raddr  = (in_kind == l2p_pkg::KIND_REMOVE) ? in_last_logical_id[AW-1:0]
                                                      : in_logical_id[AW-1:0];
        strobe_nxt = 1'b1;
        case (in_kind)
          l2p_pkg::KIND_ALLOC: begin
            if (used_r >= cap_r) begin
              status_nxt = l2p_pkg::ST_NO_CAP;
            end else begin
              slot_nxt = used_r[l2p_pkg::FW-1:0];
              used_nxt = used_r + 1'b1;
            end
          end
          l2p_pkg::KIND_PUBLISH: begin
            if (sin7 >= used_r) begin
              status_nxt = l2p_pkg::ST_UNALLOC;
            end else if (res_err_rng) begin
              status_nxt = l2p_pkg::ST_RANGE;
            end else if (valid_lid) begin
              status_nxt = l2p_pkg::ST_BOUND;
            end else begin
              tbl_we    = 1'b1;
              tbl_waddr = in_logical_id[AW-1:0];
              tbl_wdata = in_slot_in[AW-1:0];
              valid_nxt[in_logical_id[AW-1:0]] = 1'b1;
              pub_nxt   = pub_r + 1'b1;
            end
          end
          l2p_pkg::KIND_RESOLVE: begin
            if (res_err_rng) begin
              status_nxt = l2p_pkg::ST_RANGE;
            end else if (!valid_lid) begin
              status_nxt = l2p_pkg::ST_UNBOUND;
            end else begin
              strobe_nxt = 1'b0;
            end
          end
          l2p_pkg::KIND_REMOVE: begin
            if (rem_err_last) begin
              status_nxt = l2p_pkg::ST_BAD_LAST;
            end else if (rem_err_rng) begin
              status_nxt = l2p_pkg::ST_RANGE;
            end else if (rem_err_unb) begin
              status_nxt = l2p_pkg::ST_UNBOUND;
            end else begin
              strobe_nxt = 1'b0;
            end
          end
          l2p_pkg::KIND_COMPACT: begin
            strobe_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      l2p_pkg::CMD_RES_DONE: begin
        strobe_nxt = 1'b1;
        slot_nxt   = l2p_pkg::FW'(tbl_rdata);
      end
      l2p_pkg::CMD_REM_DONE: begin
        // The last id's slot goes to the removed id, then the last id is unbound.
        if (lid_r != lastid_r) begin
          tbl_we = 1'b1;
        end
        valid_nxt[lastid_r[AW-1:0]] = 1'b0;
        pub_nxt    = pub_r - 1'b1;
        strobe_nxt = 1'b1;
      end
      l2p_pkg::CMD_CMP_INIT: begin
        mark_nxt   = '0;
        id_cnt_nxt = '0;
        refd_nxt   = '0;
        psnap_nxt  = used_r;
      end
      l2p_pkg::CMD_MARK_RD: begin
        tbl_raddr = id_cnt_r[AW-1:0];
      end
      l2p_pkg::CMD_MARK_CHK: begin
        if (sts.corrupt) begin
          strobe_nxt = 1'b1;
          status_nxt = l2p_pkg::ST_CORRUPT;
        end else begin
          if (!mark_r[tbl_rdata]) begin
            mark_nxt[tbl_rdata] = 1'b1;
            refd_nxt = refd_r + 1'b1;
            scr_we   = 1'b1;
          end
          id_cnt_nxt = id_cnt_r + 1'b1;
        end
      end
      l2p_pkg::CMD_MARK_END: begin
        used_nxt   = refd_r;
        id_cnt_nxt = '0;
        t_nxt      = '0;
        src_nxt    = psnap_r;
      end
      l2p_pkg::CMD_SCAN: begin
        // A hole below the new count takes the highest referenced tail slot.
        if (mark_r[t_r[AW-1:0]]) begin
          t_nxt = t_r + 1'b1;
        end else begin
          src_nxt = src_m1;
          if (mark_r[src_m1[AW-1:0]]) begin
            scr_we     = 1'b1;
            scr_waddr  = src_m1[AW-1:0];
            scr_wdata  = t_r[AW-1:0];
            strobe_nxt = 1'b1;
            ismove_nxt = 1'b1;
            from_nxt   = src_m1[l2p_pkg::FW-1:0];
            to_nxt     = t_r[l2p_pkg::FW-1:0];
            t_nxt      = t_r + 1'b1;
          end
        end
      end
      l2p_pkg::CMD_RW_RD: begin
        tbl_raddr = id_cnt_r[AW-1:0];
      end
      l2p_pkg::CMD_RW_SC: begin
        scr_raddr = tbl_rdata;
      end
      l2p_pkg::CMD_RW_WR: begin
        tbl_we     = 1'b1;
        tbl_waddr  = id_cnt_r[AW-1:0];
        tbl_wdata  = scr_rdata;
        id_cnt_nxt = id_cnt_r + 1'b1;
      end
      l2p_pkg::CMD_FINAL: begin
        strobe_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= '0;
      used_r   <= '0;
      pub_r    <= '0;
      valid_r  <= '0;
      mark_r   <= '0;
      strobe_r <= 1'b0;
      id_cnt_r <= '0;
      refd_r   <= '0;
      psnap_r  <= '0;
      t_r      <= '0;
      src_r    <= '0;
    end else begin
      cap_r    <= cap_nxt;
      used_r   <= used_nxt;
      pub_r    <= pub_nxt;
      valid_r  <= valid_nxt;
      mark_r   <= mark_nxt;
      strobe_r <= strobe_nxt;
      id_cnt_r <= id_cnt_nxt;
      refd_r   <= refd_nxt;
      psnap_r  <= psnap_nxt;
      t_r      <= t_nxt;
      src_r    <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lid_r    <= lid_nxt;
    lastid_r <= lastid_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    ismove_r <= ismove_nxt;
    from_r   <= from_nxt;
    to_r     <= to_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_slot_out   = slot_r;
  assign out_is_move    = ismove_r;
  assign out_move_from  = from_r;
  assign out_move_to    = to_r;
  assign out_slot_count = used_r;
  assign out_pub_total  = pub_r;
  assign out_last       = !ismove_r;

  a_pub_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(pub_r))
    else $error("published count differs from bound entries");

  a_used_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= cap_r)
    else $error("slot count exceeds capacity");

  a_cap_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r <= DEPTH_C)
    else $error("capacity exceeds table depth");

  a_move_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && ismove_r) |-> (to_r < from_r))
    else $error("compaction move does not go downward");

endmodule

@@ rtl/logical_to_physical_slot_map_unit.sv @@
// Top level of the logical-to-physical slot map unit.
// Commands are accepted at a rising edge with start high and busy low; the
// kind field picks allocate, publish, resolve, remove-swap-last or compact.
// Each result beat is shown for one cycle with out_strobe high and cannot be
// held off by the receiver; out_last marks the final beat of a command.
// Allocate, publish and any rejected command give their beat in the cycle after
// acceptance and busy stays low, so one command per cycle is taken.
// A valid resolve or remove reads the table in S_RES or S_REM, with busy high.
// Compact walks the published ids twice through the table RAM: a mark pass
// marks the slot referenced by each id, a scan over the slots below the old
// count finds holes and emits moves, and a rewrite pass gives each id its new
// slot. A corrupt table ends compaction with a single beat of status 7.
// The capacity register is written through cfg_we/cfg_wdata while idle, a user
// rule the block does not enforce; it only grows and saturates at the table
// depth. Reset clears capacity, counts and all bindings at once; no sweep.
module logical_to_physical_slot_map_unit #(
  parameter int MAP_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [l2p_pkg::KW-1:0]  in_kind,
  input  logic [l2p_pkg::FW-1:0]  in_logical_id,
  input  logic [l2p_pkg::FW-1:0]  in_slot_in,
  input  logic [l2p_pkg::FW-1:0]  in_last_logical_id,
  input  logic                    cfg_we,
  input  logic [l2p_pkg::CW-1:0]  cfg_wdata,
  output logic                    out_strobe,
  output logic [l2p_pkg::SW-1:0]  out_status,
  output logic [l2p_pkg::FW-1:0]  out_slot_out,
  output logic                    out_is_move,
  output logic [l2p_pkg::FW-1:0]  out_move_from,
  output logic [l2p_pkg::FW-1:0]  out_move_to,
  output logic [l2p_pkg::CW-1:0]  out_slot_count,
  output logic [l2p_pkg::CW-1:0]  out_pub_total,
  output logic                    out_last
);

  l2p_pkg::cmd_t cmd;
  l2p_pkg::sts_t sts;

  l2p_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_kind(in_kind),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  l2p_dp #(.MAP_DEPTH(MAP_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_logical_id(in_logical_id), .in_slot_in(in_slot_in),
    .in_last_logical_id(in_last_logical_id),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_slot_out(out_slot_out),
    .out_is_move(out_is_move), .out_move_from(out_move_from),
    .out_move_to(out_move_to), .out_slot_count(out_slot_count),
    .out_pub_total(out_pub_total), .out_last(out_last)
  );

endmodule

@@ dv/logical_to_physical_slot_map_unit_test.sv @@
// Self-checking testbench for the logical-to-physical slot map unit.
module logical_to_physical_slot_map_unit_test;

  localparam int CW = l2p_pkg::CW;
  localparam int FW = l2p_pkg::FW;
  localparam int KW = l2p_pkg::KW;
  localparam int SW = l2p_pkg::SW;
  localparam int DEPTH = 64;
  localparam logic [CW-1:0] NO_SLOT = 7'h7F;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [SW-1:0] status;
    logic [FW-1:0] slot;
    logic          is_move;
    logic [FW-1:0] from_slot;
    logic [FW-1:0] to_slot;
    logic [CW-1:0] slot_count;
    logic [CW-1:0] pub_count;
    logic          last_beat;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KW-1:0] in_kind = '0;
  logic [FW-1:0] in_logical_id = '0;
  logic [FW-1:0] in_slot_in = '0;
  logic [FW-1:0] in_last_logical_id = '0;
  logic cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  logic out_strobe;
  logic [SW-1:0] out_status;
  logic [FW-1:0] out_slot_out;
  logic out_is_move;
  logic [FW-1:0] out_move_from;
  logic [FW-1:0] out_move_to;
  logic [CW-1:0] out_slot_count;
  logic [CW-1:0] out_pub_total;
  logic out_last;

  logical_to_physical_slot_map_unit #(.MAP_DEPTH(DEPTH)) u_top (.*);

  always #5 clk = ~clk;

  // Shadow copy of the map state.
  logic [CW-1:0] bind_tbl [DEPTH];
  logic [CW-1:0] slots_used;
  logic [CW-1:0] ids_published;
  logic [CW-1:0] cap_reg;

  beat_t expected_beats[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;

  function automatic void push_beat(int st, int sl, int mv, int fr, int to, int lst);
    beat_t b;
    b = '{SW'(st), FW'(sl), 1'(mv), FW'(fr), FW'(to), slots_used, ids_published, 1'(lst)};
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_compact();
    logic [CW-1:0] scratch [DEPTH];
    int n;
    int old_used;
    int refd;
    int src;
    logic [CW-1:0] s;
    n = (ids_published > DEPTH) ? DEPTH : ids_published;
    old_used = slots_used;
    refd = 0;
    foreach (scratch[i]) scratch[i] = NO_SLOT;
    for (int id = 0; id < n; id++) begin
      s = bind_tbl[id];
      if (s >= slots_used) begin
        push_beat(l2p_pkg::ST_CORRUPT, 0, 0, 0, 0, 1);
        return;
      end
      if (scratch[s[FW-1:0]] == NO_SLOT) begin
        scratch[s[FW-1:0]] = s;
        refd++;
      end
    end
    slots_used = CW'(refd);
    src = old_used;
    // Fill each hole below the new count from the highest referenced tail slot.
    for (int t = 0; t < refd; t++) begin
      if (scratch[t] != NO_SLOT) continue;
      do src--; while (src >= refd && scratch[src] == NO_SLOT);
      if (src < refd) break;
      push_beat(l2p_pkg::ST_OK, 0, 1, src, t, 0);
      scratch[src] = CW'(t);
    end
    for (int id = 0; id < n; id++) begin
      s = bind_tbl[id];
      if (s < DEPTH && scratch[s[FW-1:0]] != NO_SLOT) bind_tbl[id] = scratch[s[FW-1:0]];
    end
    push_beat(l2p_pkg::ST_OK, 0, 0, 0, 0, 1);
  endfunction

  function automatic void predict_op(logic [KW-1:0] k, logic [FW-1:0] lid,
                                     logic [FW-1:0] sl, logic [FW-1:0] lst);
    case (k)
      l2p_pkg::KIND_ALLOC: begin
        if (slots_used >= cap_reg) push_beat(l2p_pkg::ST_NO_CAP, 0, 0, 0, 0, 1);
        else begin
          slots_used++;
          push_beat(l2p_pkg::ST_OK, slots_used - 1, 0, 0, 0, 1);
        end
      end
      l2p_pkg::KIND_PUBLISH: begin
        if (sl >= slots_used) push_beat(l2p_pkg::ST_UNALLOC, 0, 0, 0, 0, 1);
        else if (lid >= cap_reg) push_beat(l2p_pkg::ST_RANGE, 0, 0, 0, 0, 1);
        else if (bind_tbl[lid] != NO_SLOT) push_beat(l2p_pkg::ST_BOUND, 0, 0, 0, 0, 1);
        else begin
          bind_tbl[lid] = {1'b0, sl};
          ids_published++;
          push_beat(l2p_pkg::ST_OK, 0, 0, 0, 0, 1);
        end
      end
      l2p_pkg::KIND_RESOLVE: begin
        if (lid >= cap_reg) push_beat(l2p_pkg::ST_RANGE, 0, 0, 0, 0, 1);
        else if (bind_tbl[lid] == NO_SLOT) push_beat(l2p_pkg::ST_UNBOUND, 0, 0, 0, 0, 1);
        else push_beat(l2p_pkg::ST_OK, bind_tbl[lid][FW-1:0], 0, 0, 0, 1);
      end
      l2p_pkg::KIND_REMOVE: begin
        if (ids_published == 0 || lst != ids_published - 1)
          push_beat(l2p_pkg::ST_BAD_LAST, 0, 0, 0, 0, 1);
        else if (lid > lst) push_beat(l2p_pkg::ST_RANGE, 0, 0, 0, 0, 1);
        else if (bind_tbl[lid] == NO_SLOT || bind_tbl[lst] == NO_SLOT)
          push_beat(l2p_pkg::ST_UNBOUND, 0, 0, 0, 0, 1);
        else begin
          bind_tbl[lid] = bind_tbl[lst];
          bind_tbl[lst] = NO_SLOT;
          ids_published--;
          push_beat(l2p_pkg::ST_OK, 0, 0, 0, 0, 1);
        end
      end
      l2p_pkg::KIND_COMPACT: predict_compact();
      default: push_beat(l2p_pkg::ST_OK, 0, 0, 0, 0, 1);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(int k, int lid, int sl, int lst);
    if (burst_left == 0) begin
      start = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    start = 1'b1;
    in_kind = KW'(k);
    in_logical_id = FW'(lid);
    in_slot_in = FW'(sl);
    in_last_logical_id = FW'(lst);
    do @(posedge clk); while (busy);
    predict_op(in_kind, in_logical_id, in_slot_in, in_last_logical_id);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CW-1:0] v);
    logic [CW-1:0] sat;
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sat = (v > DEPTH) ? CW'(DEPTH) : v;
    if (sat > cap_reg) cap_reg = sat;
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** logical_to_physical_slot_map_unit: FAILED **");
      $finish;
    end
    if (rst_n && out_strobe) begin
      got = '{out_status, out_slot_out, out_is_move, out_move_from, out_move_to,
              out_slot_count, out_pub_total, out_last};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("beat mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Capacity zero: alloc, publish, resolve and remove are rejected, others not.
  task automatic test_empty_map();
    send_op(l2p_pkg::KIND_ALLOC, 0, 0, 0);
    send_op(l2p_pkg::KIND_RESOLVE, 0, 0, 0);
    send_op(l2p_pkg::KIND_PUBLISH, 0, 0, 0);
    send_op(l2p_pkg::KIND_REMOVE, 0, 0, 0);
    send_op(l2p_pkg::KIND_COMPACT, 0, 0, 0);
    send_op(3'd5, 6'h3F, 6'h3F, 6'h3F);
    send_op(3'd7, 6'h2A, 6'h15, 6'h3F);
  endtask

  task automatic test_bind_and_lookup();
    write_capacity(7'd4);
    write_capacity(7'd2);  // must not shrink
    repeat (3) send_op(l2p_pkg::KIND_ALLOC, 0, 0, 0);
    send_op(l2p_pkg::KIND_PUBLISH, 0, 2, 0);
    send_op(l2p_pkg::KIND_PUBLISH, 0, 1, 0);    // already bound
    send_op(l2p_pkg::KIND_PUBLISH, 9, 0, 0);    // id out of range
    send_op(l2p_pkg::KIND_PUBLISH, 1, 6'h3F, 0); // slot not allocated
    send_op(l2p_pkg::KIND_PUBLISH, 1, 0, 0);
    send_op(l2p_pkg::KIND_RESOLVE, 0, 0, 0);
    send_op(l2p_pkg::KIND_RESOLVE, 2, 0, 0);    // unbound
    send_op(l2p_pkg::KIND_RESOLVE, 6'h3F, 0, 0);
    send_op(l2p_pkg::KIND_REMOVE, 2, 0, 1);     // id above last
    send_op(l2p_pkg::KIND_REMOVE, 0, 0, 0);     // wrong last id
    send_op(l2p_pkg::KIND_REMOVE, 0, 0, 1);
    send_op(l2p_pkg::KIND_PUBLISH, 1, 2, 0);
  endtask

  task automatic test_compaction();
    send_op(l2p_pkg::KIND_COMPACT, 0, 0, 0);
    // Binding id 3 with id 2 unbound leaves a hole in the published range.
    send_op(l2p_pkg::KIND_PUBLISH, 3, 1, 0);
    send_op(l2p_pkg::KIND_COMPACT, 0, 0, 0);
    send_op(l2p_pkg::KIND_PUBLISH, 2, 0, 0);
    send_op(l2p_pkg::KIND_COMPACT, 0, 0, 0);
  endtask

  task automatic random_op();
    int pick;
    int lid;
    pick = $urandom_range(0, 99);
    if (pick < 20) send_op(l2p_pkg::KIND_ALLOC, $urandom, $urandom, $urandom);
    else if (pick < 45) begin
      lid = 0;
      while (lid < DEPTH - 1 && bind_tbl[lid] != NO_SLOT) lid++;
      send_op(l2p_pkg::KIND_PUBLISH, lid,
              (slots_used == 0) ? 0 : $urandom_range(0, slots_used - 1), $urandom);
    end else if (pick < 63)
      send_op(l2p_pkg::KIND_RESOLVE, (ids_published == 0) ? $urandom
              : $urandom_range(0, ids_published - 1), $urandom, $urandom);
    else if (pick < 80) begin
      lid = (ids_published == 0) ? 0 : ids_published - 1;
      send_op(l2p_pkg::KIND_REMOVE, $urandom_range(0, lid), $urandom, lid);
    end else if (pick < 88) send_op(l2p_pkg::KIND_COMPACT, $urandom, $urandom, $urandom);
    else send_op($urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_traffic();
    logic [CW-1:0] caps [4];
    caps = '{7'd12, 7'd30, 7'd127, 7'd64};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      repeat (76) random_op();
    end
  endtask

  initial begin
    foreach (bind_tbl[i]) bind_tbl[i] = NO_SLOT;
    slots_used = 0;
    ids_published = 0;
    cap_reg = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_empty_map();
    test_bind_and_lookup();
    test_compaction();
    test_random_traffic();
    drain();
    repeat (400) @(negedge clk);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("** logical_to_physical_slot_map_unit: PASSED **");
    else
      $display("** logical_to_physical_slot_map_unit: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/l2p_pkg.sv
rtl/l2p_ram.sv
rtl/l2p_ctrl.sv
rtl/l2p_dp.sv
rtl/logical_to_physical_slot_map_unit.sv
dv/logical_to_physical_slot_map_unit_test.sv
